[rtl/sacl_pkg.sv]
// Shared constants, types and command bundle of the set-associative cache lookup block.
package sacl_pkg;

	// Cache geometry.
	localparam int LOG_SETS = 6;
	localparam int WAYS     = 4;
	localparam int SETS     = 1 << LOG_SETS;
	localparam int SET_W    = (LOG_SETS > 0) ? LOG_SETS : 1;
	localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

	// Field widths.
	localparam int ADDR_W  = 32;
	localparam int TAG_W   = 32;
	localparam int RANK_W  = 4;
	localparam int OFFS_W  = 4;
	localparam int CNT_W   = 32;
	localparam int WAYO_W  = 4;
	localparam int TSH_W   = 6;

	// Reset value of the block-offset register.
	localparam logic [OFFS_W-1:0] OFFS_RESET = OFFS_W'(2);

	// Rank given to an invalid way when it is touched: older than any real rank.
	localparam logic [RANK_W:0] RANK_NONE = (RANK_W + 1)'(16);

	typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;
	typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the address, start the row read
		logic update;  // compare, update the set and report the result
	} sacl_cmd_t;

endpackage

[rtl/sacl_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/sacl_ctrl.sv]
// Controller state machine: sequences the row read and the update of one lookup.
module sacl_ctrl
	import sacl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output sacl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CMP  = 1'b1;

	logic state_q;
	logic state_d;

	// Next state: a beat is taken in idle, the following cycle updates the set.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Commands and status.
	assign busy       = (state_q == ST_CMP);
	assign cmd.load   = (state_q == ST_IDLE) && start;
	assign cmd.update = (state_q == ST_CMP);

	// A load is always followed by exactly one update.
	a_load_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.update)
		else $error("load not followed by update");

	// Updates never come back to back.
	a_update_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> !cmd.update)
		else $error("update lasted more than one cycle");

endmodule

[rtl/sacl_dp.sv]
// Datapath: address split, tag and rank rows, hit check, replacement and counters.
module sacl_dp
	import sacl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  sacl_cmd_t         cmd,
	input  logic              cfg_wr_en,
	input  logic [OFFS_W-1:0] cfg_wr_data,
	input  logic [ADDR_W-1:0] address,
	output logic              done,
	output logic              hit,
	output logic [WAYO_W-1:0] way_used,
	output logic [CNT_W-1:0]  access_count,
	output logic [CNT_W-1:0]  hit_count
);

	logic [OFFS_W-1:0] offset_q;
	logic [SET_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [WAYS-1:0]   valid_q [SETS];
	logic [CNT_W-1:0]  acc_q;
	logic [CNT_W-1:0]  hits_q;
	logic              done_q;
	logic              hit_q;
	logic [WAY_W-1:0]  way_q;

	logic [ADDR_W-1:0] shifted;
	logic [SET_W-1:0]  set_in;
	logic [TSH_W-1:0]  tshift;
	logic [TAG_W-1:0]  tag_in;

	tag_row_t          tag_row;
	rank_row_t         rank_row;
	tag_row_t          tag_row_new;
	rank_row_t         rank_row_new;
	logic [WAYS-1:0]   valid_row;
	logic [WAYS-1:0]   hit_vec;
	logic              any_hit;
	logic              any_free;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  free_way;
	logic [WAY_W-1:0]  lru_way;
	logic [RANK_W-1:0] lru_rank;
	logic [WAY_W-1:0]  chosen;
	logic [RANK_W:0]   old_rank;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFS_RESET;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	// Split the incoming address into set index and tag.
	always_comb begin
		shifted = address >> offset_q;
		set_in  = shifted[SET_W-1:0];
		if (LOG_SETS == 0) begin
			set_in = '0;
		end
		tshift = TSH_W'(offset_q) + TSH_W'(LOG_SETS);
		tag_in = (tshift >= TSH_W'(ADDR_W)) ? '0 : TAG_W'(address >> tshift);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			set_q <= set_in;
			tag_q <= tag_in;
		end
	end

	// Tag and rank rows of every set; read at the accept beat, written on update.
	sacl_ram #(.WIDTH(WAYS * TAG_W), .DEPTH(SETS)) u_tag_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (set_q),
		.wdata (tag_row_new),
		.re    (cmd.load),
		.raddr (set_in),
		.rdata (tag_row)
	);

	sacl_ram #(.WIDTH(WAYS * RANK_W), .DEPTH(SETS)) u_rank_ram (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (set_q),
		.wdata (rank_row_new),
		.re    (cmd.load),
		.raddr (set_in),
		.rdata (rank_row)
	);

	assign valid_row = valid_q[set_q];

	// Hit check, free way search and least recently used victim.
	always_comb begin
		any_hit  = 1'b0;
		any_free = 1'b0;
		hit_way  = '0;
		free_way = '0;
		lru_way  = '0;
		lru_rank = rank_row[0];
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = valid_row[w] && (tag_row[w] == tag_q);
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				any_hit = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!valid_row[w]) begin
				any_free = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		for (int w = 1; w < WAYS; w++) begin
			if (rank_row[w] > lru_rank) begin
				lru_rank = rank_row[w];
				lru_way  = WAY_W'(w);
			end
		end
		if (any_hit) begin
			chosen = hit_way;
		end else if (any_free) begin
			chosen = free_way;
		end else begin
			chosen = lru_way;
		end
	end

	// Recency update and new tag row.
	always_comb begin
		old_rank = valid_row[chosen] ? {1'b0, rank_row[chosen]} : RANK_NONE;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) == chosen) begin
				rank_row_new[w] = '0;
				tag_row_new[w]  = tag_q;
			end else begin
				tag_row_new[w] = tag_row[w];
				if (valid_row[w] && ({1'b0, rank_row[w]} < old_rank)) begin
					rank_row_new[w] = rank_row[w] + RANK_W'(1);
				end else begin
					rank_row_new[w] = rank_row[w];
				end
			end
		end
	end

	// Valid bits: cleared at reset, set when a way is filled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (cmd.update) begin
			valid_q[set_q][chosen] <= 1'b1;
		end
	end

	// Running counters and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			hits_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				acc_q  <= acc_q + CNT_W'(1);
				hits_q <= hits_q + CNT_W'(any_hit);
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q <= any_hit;
			way_q <= chosen;
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign way_used     = WAYO_W'(way_q);
	assign access_count = acc_q;
	assign hit_count    = hits_q;

	// A tag is never held valid in two ways of the same set.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $onehot0(hit_vec))
		else $error("tag matched in more than one way");

	// The way used by an update is valid afterwards.
	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> valid_q[$past(set_q)][$past(chosen)])
		else $error("filled way not marked valid");

	// The hit counter moves only on a reported hit.
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (hits_q == $past(hits_q) + CNT_W'(hit_q)))
		else $error("hit counter out of step with hit flag");

endmodule

[rtl/set_assoc_cache_lru_lookup.sv]
// Top level of the set-associative cache tag lookup with LRU replacement.
//
// Usage: drive an address and raise start; the beat is taken at a rising edge
// where start is high and busy is low. The set index and tag are cut from the
// address using the block-offset width held in the configuration register,
// written through cfg_wr_en and cfg_wr_data; the user must write it only while
// no lookup is in flight, which the block does not enforce. In the cycle after
// the beat is taken the tag and rank rows of the set, read from RAM at the
// accept edge, are compared and the set is written back. The result (hit,
// way_used, access_count, hit_count) is shown for exactly one cycle with done
// high; done is registered from the update, so it rises as the set is written
// back. No new address is taken while busy is high, as the registered row read
// is followed by the compare and write-back of the same row; a new beat may be
// taken in the cycle in which the previous result is shown.
// The receiver cannot stall: each result must be taken in its done cycle.
// Reset clears all valid bits, both counters and the state machine, and
// sets the offset width to 2; no clearing pass is needed.
module set_assoc_cache_lru_lookup
	import sacl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [ADDR_W-1:0] address,
	input  logic              cfg_wr_en,
	input  logic [OFFS_W-1:0] cfg_wr_data,
	output logic              done,
	output logic              hit,
	output logic [WAYO_W-1:0] way_used,
	output logic [CNT_W-1:0]  access_count,
	output logic [CNT_W-1:0]  hit_count
);

	sacl_cmd_t cmd;

	// Controller.
	sacl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath.
	sacl_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.address      (address),
		.done         (done),
		.hit          (hit),
		.way_used     (way_used),
		.access_count (access_count),
		.hit_count    (hit_count)
	);

endmodule
